FILE: src/probe_window_gc_screen_core_macros.svh
// Assertion macros for the probe window GC screen checker.
// Every macro samples on clk_i and is disabled while rst_ni is low.
`ifndef PROBE_WINDOW_GC_SCREEN_CORE_MACROS_SVH
`define PROBE_WINDOW_GC_SCREEN_CORE_MACROS_SVH

// same-cycle implication
`define PWGC_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("pwgc assertion failed");

// next-cycle implication
`define PWGC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("pwgc assertion failed");

`endif

FILE: src/pwgc_pkg.sv
// Shared types and constants for the probe window GC screen.
// No dependencies; used by the core, the result queue and the checker.
package pwgc_pkg;

  localparam int unsigned MAX_WINDOW_DEF     = 128;
  localparam int unsigned MAX_CANDIDATES_DEF = 128;

  localparam logic [7:0] CHAR_C     = 8'h43;
  localparam logic [7:0] CHAR_G     = 8'h47;
  localparam logic [7:0] CHAR_LOW_A = 8'h61;
  localparam logic [7:0] CHAR_LOW_Z = 8'h7a;

  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_REPEATS  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RELAXED_MIN  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RELAXED_MAX  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_STRINGENT_MIN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_STRINGENT_MAX = 3'd4;

  localparam logic [7:0] MAX_REPEATS_RST   = 8'd10;
  localparam logic [7:0] RELAXED_MIN_RST   = 8'd48;
  localparam logic [7:0] RELAXED_MAX_RST   = 8'd84;
  localparam logic [7:0] STRINGENT_MIN_RST = 8'd60;
  localparam logic [7:0] STRINGENT_MAX_RST = 8'd72;

  // result queue depth; input is taken while two slots are free
  localparam int unsigned RES_DEPTH = 4;
  localparam int unsigned RES_PTR_W = $clog2(RES_DEPTH);
  localparam int unsigned RES_CNT_W = $clog2(RES_DEPTH + 1);

  typedef enum logic {
    KIND_WINDOW = 1'b0,
    KIND_SET    = 1'b1
  } kind_e;

  // set decisions reuse the codes: stringent, backup, none
  typedef enum logic [1:0] {
    V_STRINGENT = 2'd0,
    V_RELAXED   = 2'd1,
    V_REJECTED  = 2'd2
  } verdict_e;

  typedef struct packed {
    kind_e      kind;
    logic [6:0] window_index;
    logic [7:0] repeat_count;
    logic [7:0] gc_count;
    verdict_e   verdict;
    logic       last;
  } res_t;

endpackage

FILE: src/pwgc_res_fifo.sv
// Result queue: takes up to two result beats per cycle, hands out one.
// Depends on pwgc_pkg.
module pwgc_res_fifo (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [1:0]                 push_n_i,
  input  pwgc_pkg::res_t             res0_i,
  input  pwgc_pkg::res_t             res1_i,
  output logic                       space2_o,
  output logic                       valid_o,
  input  logic                       pop_i,
  output pwgc_pkg::res_t             head_o
);
  import pwgc_pkg::*;

  res_t                 mem_q [RES_DEPTH];
  logic [RES_PTR_W-1:0] wr_ptr_q, wr_ptr_d, wr_nxt;
  logic [RES_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [RES_CNT_W-1:0] cnt_q, cnt_d;
  logic                 pop;

  assign valid_o  = (cnt_q != '0);
  assign space2_o = (cnt_q <= RES_CNT_W'(RES_DEPTH - 2));
  assign pop      = pop_i && valid_o;
  assign head_o   = mem_q[rd_ptr_q];
  assign wr_nxt   = wr_ptr_q + RES_PTR_W'(1);

  always_comb begin
    wr_ptr_d = wr_ptr_q + RES_PTR_W'(push_n_i);
    rd_ptr_d = pop ? rd_ptr_q + RES_PTR_W'(1) : rd_ptr_q;
    cnt_d    = cnt_q + RES_CNT_W'(push_n_i) - RES_CNT_W'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_n_i != 2'd0) begin
      mem_q[wr_ptr_q] <= res0_i;
    end
    if (push_n_i == 2'd2) begin
      mem_q[wr_nxt] <= res1_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

FILE: src/probe_window_gc_screen_core.sv
// Channel   Dir  tdata                    tuser       tlast
// s_axis    in   [7:0] base               [0] set_end window_end
// m_axis    out  [6:0] window_index,      [0] kind    last
//                [14:7] repeat_count, [22:15] gc_count, [24:23] verdict
// cfg       in   cfg_we_i / cfg_index_i / cfg_wdata_i, write only
//
// One base is taken per cycle while s_axis_tready is high; its results are in the result queue the next cycle.
// An item that closes a window and its set gives two output beats, unless its set already has a stringent window.
// s_axis_tready drops while the four-entry result queue has under two free slots.
// Reset clears the tallies and set state and loads register defaults.
// Top level of the probe window GC screen; depends on pwgc_pkg and pwgc_res_fifo.
module probe_window_gc_screen_core #(
  parameter int unsigned MAX_WINDOW     = pwgc_pkg::MAX_WINDOW_DEF,
  parameter int unsigned MAX_CANDIDATES = pwgc_pkg::MAX_CANDIDATES_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,  // [7:0] base
  input  logic [0:0]                    s_axis_tuser,  // [0] set_end
  input  logic                          s_axis_tlast,  // window_end
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [6:0] window_index, [14:7] repeat_count, [22:15] gc_count, [24:23] verdict
  output logic [31:0]                   m_axis_tdata,
  output logic [0:0]                    m_axis_tuser,  // [0] kind
  output logic                          m_axis_tlast,  // last
  input  logic                          cfg_we_i,
  input  logic [pwgc_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [7:0]                    cfg_wdata_i
);
  import pwgc_pkg::*;

  localparam logic [7:0] CountSat = (MAX_WINDOW > 255) ? 8'd255 : 8'(MAX_WINDOW);
  localparam logic [6:0] IndexSat = (MAX_CANDIDATES > 128) ? 7'd127 :
                                    7'(MAX_CANDIDATES - 1);

  logic [7:0] max_rep_q, rlx_min_q, rlx_max_q, str_min_q, str_max_q;

  logic [7:0] rep_q, rep_d, gc_q, gc_d;
  logic [6:0] win_q, win_d;
  logic       str_found_q, str_found_d, bak_valid_q, bak_valid_d;
  logic [6:0] ch_idx_q, ch_idx_d;
  logic [7:0] ch_rep_q, ch_rep_d, ch_gc_q, ch_gc_d;

  logic       in_acc, wend, send, close;
  logic       is_lower, is_gc;
  logic [7:0] rep_now, gc_now;
  logic       relaxed, stringent;
  verdict_e   win_verdict;

  logic [1:0] push_n;
  res_t       res0, res1, dec, head;
  logic       space2;

  assign in_acc = s_axis_tvalid && s_axis_tready;
  assign wend   = s_axis_tlast;
  assign send   = s_axis_tuser[0];
  assign close  = wend || send;

  assign is_lower = (s_axis_tdata >= CHAR_LOW_A) && (s_axis_tdata <= CHAR_LOW_Z);
  assign is_gc    = (s_axis_tdata == CHAR_C) || (s_axis_tdata == CHAR_G);
  assign rep_now  = (is_lower && rep_q < CountSat) ? rep_q + 8'd1 : rep_q;
  assign gc_now   = (is_gc && gc_q < CountSat) ? gc_q + 8'd1 : gc_q;

  assign relaxed   = (rep_now <= max_rep_q) && (gc_now >= rlx_min_q) && (gc_now <= rlx_max_q);
  assign stringent = relaxed && (gc_now >= str_min_q) && (gc_now <= str_max_q);
  assign win_verdict = stringent ? V_STRINGENT : (relaxed ? V_RELAXED : V_REJECTED);

  always_comb begin
    rep_d       = rep_q;
    gc_d        = gc_q;
    win_d       = win_q;
    str_found_d = str_found_q;
    bak_valid_d = bak_valid_q;
    ch_idx_d    = ch_idx_q;
    ch_rep_d    = ch_rep_q;
    ch_gc_d     = ch_gc_q;
    res0        = '0;
    res1        = '0;
    dec         = '0;
    push_n      = 2'd0;

    if (in_acc) begin
      // everything after a stringent pass is dropped until set end
      if (!str_found_q) begin
        rep_d = rep_now;
        gc_d  = gc_now;
        if (close) begin
          if (stringent) begin
            str_found_d = 1'b1;
          end
          if (stringent || (relaxed && !bak_valid_q)) begin
            bak_valid_d = bak_valid_q || !stringent;
            ch_idx_d    = win_q;
            ch_rep_d    = rep_now;
            ch_gc_d     = gc_now;
          end
          res0.kind         = KIND_WINDOW;
          res0.window_index = win_q;
          res0.repeat_count = rep_now;
          res0.gc_count     = gc_now;
          res0.verdict      = win_verdict;
          res0.last         = !send;
          push_n            = 2'd1;
          rep_d             = '0;
          gc_d              = '0;
          win_d             = (win_q < IndexSat) ? win_q + 7'd1 : win_q;
        end
      end

      if (send) begin
        dec.kind = KIND_SET;
        dec.last = 1'b1;
        if (str_found_d || bak_valid_d) begin
          dec.window_index = ch_idx_d;
          dec.repeat_count = ch_rep_d;
          dec.gc_count     = ch_gc_d;
          dec.verdict      = str_found_d ? V_STRINGENT : V_RELAXED;
        end else begin
          dec.verdict = V_REJECTED;
        end
        if (push_n == 2'd1) begin
          res1   = dec;
          push_n = 2'd2;
        end else begin
          res0   = dec;
          push_n = 2'd1;
        end
        rep_d       = '0;
        gc_d        = '0;
        win_d       = '0;
        str_found_d = 1'b0;
        bak_valid_d = 1'b0;
        ch_idx_d    = '0;
        ch_rep_d    = '0;
        ch_gc_d     = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rep_q       <= '0;
      gc_q        <= '0;
      win_q       <= '0;
      str_found_q <= 1'b0;
      bak_valid_q <= 1'b0;
      ch_idx_q    <= '0;
      ch_rep_q    <= '0;
      ch_gc_q     <= '0;
    end else begin
      rep_q       <= rep_d;
      gc_q        <= gc_d;
      win_q       <= win_d;
      str_found_q <= str_found_d;
      bak_valid_q <= bak_valid_d;
      ch_idx_q    <= ch_idx_d;
      ch_rep_q    <= ch_rep_d;
      ch_gc_q     <= ch_gc_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_rep_q <= MAX_REPEATS_RST;
      rlx_min_q <= RELAXED_MIN_RST;
      rlx_max_q <= RELAXED_MAX_RST;
      str_min_q <= STRINGENT_MIN_RST;
      str_max_q <= STRINGENT_MAX_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_MAX_REPEATS:   max_rep_q <= cfg_wdata_i;
        CFG_RELAXED_MIN:   rlx_min_q <= cfg_wdata_i;
        CFG_RELAXED_MAX:   rlx_max_q <= cfg_wdata_i;
        CFG_STRINGENT_MIN: str_min_q <= cfg_wdata_i;
        CFG_STRINGENT_MAX: str_max_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  pwgc_res_fifo u_res_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_n_i (push_n),
    .res0_i   (res0),
    .res1_i   (res1),
    .space2_o (space2),
    .valid_o  (m_axis_tvalid),
    .pop_i    (m_axis_tready),
    .head_o   (head)
  );

  assign s_axis_tready = space2;
  assign m_axis_tdata  = {7'd0, 2'(head.verdict), head.gc_count, head.repeat_count,
                          head.window_index};
  assign m_axis_tuser  = 1'(head.kind);
  assign m_axis_tlast  = head.last;

endmodule

FILE: src/pwgc_checker.sv
// Port-level checker for probe_window_gc_screen_core, bound to the top level.
// Depends on probe_window_gc_screen_core_macros.svh and pwgc_pkg.
`include "probe_window_gc_screen_core_macros.svh"

module pwgc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic [0:0]  m_axis_tuser,
  input logic        m_axis_tlast
);
  import pwgc_pkg::*;

  logic        out_stall, out_set;
  logic [33:0] out_beat;
  logic [1:0]  out_verdict;

  assign out_stall   = m_axis_tvalid && !m_axis_tready;
  assign out_set     = m_axis_tvalid && m_axis_tuser[0];
  assign out_beat    = {m_axis_tlast, m_axis_tuser, m_axis_tdata};
  assign out_verdict = m_axis_tdata[24:23];

  // stalled result beat stays up
  `PWGC_ASSERT_NEXT(a_out_hold, out_stall, m_axis_tvalid)

  // stalled result beat keeps its payload
  `PWGC_ASSERT_NEXT(a_out_stable, out_stall, $stable(out_beat))

  // a set decision always closes the beats of its item
  `PWGC_ASSERT_IMPLY(a_set_last, out_set, m_axis_tlast)

  // verdict code three never appears, padding stays zero
  `PWGC_ASSERT_IMPLY(a_verdict_ok, m_axis_tvalid, out_verdict != 2'd3 && m_axis_tdata[31:25] == 7'd0)

  // "none found" decision carries zero index and counts
  `PWGC_ASSERT_IMPLY(a_none_zero, out_set && out_verdict == 2'(V_REJECTED), m_axis_tdata[22:0] == 23'd0)

endmodule

bind probe_window_gc_screen_core pwgc_checker u_pwgc_checker (.*);
